// ===== hw/rtl/rbnh_pkg.sv =====
// rbnh_pkg: shared constants and types for the ray/box nearest-hit block
// used by rbnh_div and ray_box_nearest_hit; no dependencies
`default_nettype none

package rbnh_pkg;

  // coordinate format: signed fixed point, CW bits with FB fraction bits
  localparam int CW = 32;
  localparam int FB = 16;
  localparam int CNT_W = $clog2(CW);

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  // reset values
  localparam logic [CW-1:0] DIR_X_RESET    = CW'(1) << FB;
  localparam logic [CW-2:0] MAX_DIST_RESET = (CW-1)'(327680);

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic signed [CW:0]   num;
    logic signed [CW-1:0] den;
  } rbnh_div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] quot;
  } rbnh_div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rbnh_div.sv =====
// rbnh_div: iterative fixed-point divider, one quotient bit per cycle,
// truncating toward zero and saturating; depends on rbnh_pkg
`default_nettype none

module rbnh_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rbnh_pkg::rbnh_div_req_t req,
  output rbnh_pkg::rbnh_div_rsp_t      rsp
);
  import rbnh_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_LOAD = 4'b0010,
    D_ITER = 4'b0100,
    D_DONE = 4'b1000
  } div_state_t;

  div_state_t          st;
  logic                neg;
  logic                ovf;
  logic [CW:0]         un;
  logic [CW-1:0]       ud;
  logic [CW-1:0]       rem;
  logic [CW-1:0]       sh;
  logic [CW-1:0]       q;
  logic [CNT_W-1:0]    cnt;

  logic [CW:0]         r2;
  logic                ge;
  logic [CW:0]         diff;
  logic [CW+FB-1:0]    un_wide;
  logic [CW+FB-1:0]    ud_wide;
  logic [CW-1:0]       lim;
  logic [CW-1:0]       mag;

  // one restoring step
  always_comb begin
    r2   = {rem, sh[CW-1]};
    ge   = (r2 >= {1'b0, ud});
    diff = r2 - {1'b0, ud};
  end

  // overflow test: quotient would need more than CW bits
  assign un_wide = (CW+FB)'(un);
  assign ud_wide = {ud, {FB{1'b0}}};

  // saturation bound depends on result sign
  assign lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign mag = (ovf || (q > lim)) ? lim : q;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (st)
        D_IDLE: begin
          if (req.start) begin
            un  <= req.num[CW] ? (CW+1)'(-req.num) : (CW+1)'(req.num);
            ud  <= req.den[CW-1] ? CW'(-req.den) : CW'(req.den);
            neg <= req.num[CW] ^ req.den[CW-1];
            st  <= D_LOAD;
          end
        end
        D_LOAD: begin
          if (un_wide >= ud_wide) begin
            ovf <= 1'b1;
            st  <= D_DONE;
          end else begin
            ovf <= 1'b0;
            rem <= CW'(un >> FB);
            sh  <= {un[FB-1:0], {(CW-FB){1'b0}}};
            q   <= '0;
            cnt <= CNT_W'(CW-1);
            st  <= D_ITER;
          end
        end
        D_ITER: begin
          rem <= ge ? diff[CW-1:0] : r2[CW-1:0];
          q   <= {q[CW-2:0], ge};
          sh  <= {sh[CW-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            st <= D_DONE;
          end
        end
        D_DONE: begin
          rsp.quot <= neg ? -mag : mag;
          rsp.done <= 1'b1;
          st       <= D_IDLE;
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ray_box_nearest_hit.sv =====
// ray_box_nearest_hit: nearest hit of one configured ray against a stream of boxes
// operation: a box under test runs six slab divisions in turn on one shared
//   bit-serial divider (up to 32 quotient bits each); a skipped word goes
//   straight to the finish state; one word in flight at a time
// result word loads in S_FIN, after S_DECIDE or a skipped word's acceptance, once out_free
// reset: synchronous, clears the running best and loads register defaults
// depends on rbnh_pkg and rbnh_div
`default_nettype none

module ray_box_nearest_hit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [rbnh_pkg::CW-1:0]    cfg_data,
  // input words
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                entity_id,
  input  wire logic                       box_present,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_min_x,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_max_x,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_min_y,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_max_y,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_min_z,
  input  wire logic signed [rbnh_pkg::CW-1:0] box_max_z,
  input  wire logic                       last_entity,
  // result words
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            hit_found,
  output logic [31:0]                     hit_entity_id,
  output logic [rbnh_pkg::CW-2:0]         hit_distance
);
  import rbnh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_WAIT   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t                state;

  // ray registers
  logic signed [CW-1:0]  origin [3];
  logic signed [CW-1:0]  dir [3];
  logic [CW-2:0]         max_distance;

  // captured word
  logic [31:0]           id;
  logic signed [CW-1:0]  box_lo [3];
  logic signed [CW-1:0]  box_hi [3];
  logic                  last;

  // slab work
  logic [2:0]            k;
  logic [1:0]            axis;
  logic signed [CW-1:0]  t1;
  logic signed [CW-1:0]  tmin;
  logic signed [CW-1:0]  tmax;
  logic signed [CW:0]    op_num;
  logic signed [CW-1:0]  op_den;
  logic                  div_start;

  // running best
  logic [CW-1:0]         best_distance;
  logic [31:0]           best_id;
  logic                  any_hit;

  rbnh_div_req_t         dreq;
  rbnh_div_rsp_t         drsp;

  logic signed [CW-1:0]  bound;
  logic signed [CW-1:0]  near_t;
  logic signed [CW-1:0]  far_t;
  logic                  miss;
  logic signed [CW-1:0]  hit;
  logic                  take;
  logic                  out_free;
  logic                  fin_load;
  logic [CW-1:0]         clear_dist;

  assign in_ready = (state == S_IDLE);
  assign axis     = k[2:1];
  assign bound    = k[0] ? box_hi[axis] : box_lo[axis];
  assign out_free = !out_valid || out_ready;
  assign fin_load = (state == S_FIN) && last && out_free;
  assign clear_dist = {1'b0, max_distance} + 1'b1;

  // order the two slab parameters
  assign near_t = (t1 < drsp.quot) ? t1 : drsp.quot;
  assign far_t  = (t1 < drsp.quot) ? drsp.quot : t1;

  // final hit decision
  assign miss = tmax[CW-1] || (tmin > tmax);
  assign hit  = tmin[CW-1] ? tmax : tmin;
  assign take = !miss && (CW'(hit) <= {1'b0, max_distance})
                && (!any_hit || (CW'(hit) < best_distance));

  assign dreq = '{start: div_start, num: op_num, den: op_den};

  rbnh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0]    <= '0;
      origin[1]    <= '0;
      origin[2]    <= '0;
      dir[0]       <= DIR_X_RESET;
      dir[1]       <= '0;
      dir[2]       <= '0;
      max_distance <= MAX_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0]    <= cfg_data;
        REG_ORIGIN_Y: origin[1]    <= cfg_data;
        REG_ORIGIN_Z: origin[2]    <= cfg_data;
        REG_DIR_X:    dir[0]       <= cfg_data;
        REG_DIR_Y:    dir[1]       <= cfg_data;
        REG_DIR_Z:    dir[2]       <= cfg_data;
        REG_MAX_DIST: max_distance <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // capture an accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id        <= entity_id;
      box_lo[0] <= box_min_x;
      box_hi[0] <= box_max_x;
      box_lo[1] <= box_min_y;
      box_hi[1] <= box_max_y;
      box_lo[2] <= box_min_z;
      box_hi[2] <= box_max_z;
      last      <= last_entity;
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and running best
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      div_start     <= 1'b0;
      any_hit       <= 1'b0;
      best_id       <= '0;
      best_distance <= {1'b0, MAX_DIST_RESET} + 1'b1;
      k             <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            k <= '0;
            state <= (entity_id != '0 && box_present) ? S_PREP : S_FIN;
          end
        end
        // operands for the next slab division
        S_PREP: begin
          op_num    <= (CW+1)'(bound) - (CW+1)'(origin[axis]);
          op_den    <= (dir[axis] == '0) ? CW'(1) : dir[axis];
          div_start <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (drsp.done) begin
            if (!k[0]) begin
              t1 <= drsp.quot;
            end else if (k == 3'd1) begin
              tmin <= near_t;
              tmax <= far_t;
            end else begin
              if (near_t > tmin) tmin <= near_t;
              if (far_t < tmax)  tmax <= far_t;
            end
            if (k == 3'd5) begin
              state <= S_DECIDE;
            end else begin
              k     <= k + 1'b1;
              state <= S_PREP;
            end
          end
        end
        S_DECIDE: begin
          if (take) begin
            best_distance <= CW'(hit);
            best_id       <= id;
            any_hit       <= 1'b1;
          end
          state <= S_FIN;
        end
        // report and clear on the last word
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            hit_found     <= any_hit;
            hit_entity_id <= any_hit ? best_id : '0;
            hit_distance  <= any_hit ? best_distance[CW-2:0] : '0;
            best_distance <= clear_dist;
            best_id       <= '0;
            any_hit       <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider answers only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_WAIT)
    else $error("divider result outside wait");

  // a kept hit is always a non-negative distance
  a_best_nonneg: assert property (@(posedge clk) disable iff (rst)
    any_hit |-> !best_distance[CW-1])
    else $error("kept distance out of range");

  // no kept id without a hit
  a_id_needs_hit: assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> best_id == '0)
    else $error("stale id kept");

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("word accepted without work");

endmodule

`default_nettype wire

// ===== sim/tb_ray_box_nearest_hit.sv =====
// tb_ray_box_nearest_hit: self-checking testbench for the ray/box nearest-hit block
// predicts each result word from its own slab-method model; depends on rbnh_pkg
// and the ray_box_nearest_hit rtl
`timescale 1ns / 100ps

module tb_ray_box_nearest_hit;
  import rbnh_pkg::*;

  typedef struct {
    bit [31:0] id;
    bit        present;
    bit [31:0] bound[6];  // min_x, max_x, min_y, max_y, min_z, max_z
    bit        last;
  } box_word_t;

  typedef struct {
    bit        found;
    bit [31:0] id;
    bit [30:0] distance;
  } hit_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] entity_id;
  logic        box_present;
  logic signed [31:0] box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z;
  logic        last_entity;
  logic        out_valid;
  logic        out_ready;
  logic        hit_found;
  logic [31:0] hit_entity_id;
  logic [30:0] hit_distance;

  ray_box_nearest_hit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .entity_id(entity_id), .box_present(box_present),
    .box_min_x(box_min_x), .box_max_x(box_max_x),
    .box_min_y(box_min_y), .box_max_y(box_max_y),
    .box_min_z(box_min_z), .box_max_z(box_max_z),
    .last_entity(last_entity),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit_found(hit_found), .hit_entity_id(hit_entity_id), .hit_distance(hit_distance)
  );

  // predictor state: ray registers and running nearest hit
  longint          ray_origin[3];
  longint          ray_dir[3];
  longint unsigned reach_limit;
  longint unsigned nearest_dist;
  bit [31:0]       nearest_id;
  bit              have_hit;

  hit_word_t expected_hits[$];
  int        errors;
  bit        idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit [31:0] fx(input int whole);
    return 32'(whole) << FB;
  endfunction

  function automatic bit [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // slab parameter: exact quotient truncated toward zero, saturated to 32 bits
  function automatic longint slab_param(input longint num, input longint den);
    bit neg;
    longint unsigned un, ud, lim, q, r, f, mag;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? longint'(-num) : num;
    ud = den < 0 ? longint'(-den) : den;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q = un / ud;
    r = un % ud;
    f = 0;
    if (q > (lim >> FB)) mag = lim;
    else begin
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        f = f << 1;
        if (r >= ud) begin
          r = r - ud;
          f = f | 1;
        end
      end
      mag = (q << FB) | f;
      if (mag > lim) mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void clear_nearest();
    nearest_dist = reach_limit + 1;
    nearest_id = 0;
    have_hit = 0;
  endfunction

  // evaluate one accepted box word, queue a result word on the last one
  function automatic void track_nearest(input box_word_t w);
    longint tmin, tmax, t1, t2, lo, hi, d, hit;
    hit_word_t res;
    tmin = 0;
    tmax = 0;
    if (w.id != 0 && w.present) begin
      for (int a = 0; a < 3; a++) begin
        d = ray_dir[a] != 0 ? ray_dir[a] : 1;
        lo = longint'($signed(w.bound[2*a]));
        hi = longint'($signed(w.bound[2*a+1]));
        t1 = slab_param(lo - ray_origin[a], d);
        t2 = slab_param(hi - ray_origin[a], d);
        if (a == 0 || (t1 < t2 ? t1 : t2) > tmin) tmin = t1 < t2 ? t1 : t2;
        if (a == 0 || (t1 < t2 ? t2 : t1) < tmax) tmax = t1 < t2 ? t2 : t1;
      end
      if (!(tmax < 0 || tmin > tmax)) begin
        hit = tmin >= 0 ? tmin : tmax;
        if (longint'(hit) <= longint'(reach_limit) &&
            (!have_hit || longint'(hit) < longint'(nearest_dist))) begin
          nearest_dist = hit;
          nearest_id = w.id;
          have_hit = 1;
        end
      end
    end
    if (w.last) begin
      res.found = have_hit;
      res.id = have_hit ? nearest_id : 32'd0;
      res.distance = have_hit ? nearest_dist[30:0] : 31'd0;
      expected_hits.push_back(res);
      clear_nearest();
    end
  endfunction

  // register write, only while the block is idle
  task automatic cfg_write(input logic [2:0] idx, input bit [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_origin[0] = longint'($signed(value));
      REG_ORIGIN_Y: ray_origin[1] = longint'($signed(value));
      REG_ORIGIN_Z: ray_origin[2] = longint'($signed(value));
      REG_DIR_X:    ray_dir[0] = longint'($signed(value));
      REG_DIR_Y:    ray_dir[1] = longint'($signed(value));
      REG_DIR_Z:    ray_dir[2] = longint'($signed(value));
      REG_MAX_DIST: reach_limit = value & 32'h7fff_ffff;
      default: ;
    endcase
  endtask

  task automatic set_ray(input bit [31:0] o[3], input bit [31:0] d[3], input bit [31:0] m);
    cfg_write(REG_ORIGIN_X, o[0]);
    cfg_write(REG_ORIGIN_Y, o[1]);
    cfg_write(REG_ORIGIN_Z, o[2]);
    cfg_write(REG_DIR_X, d[0]);
    cfg_write(REG_DIR_Y, d[1]);
    cfg_write(REG_DIR_Z, d[2]);
    cfg_write(REG_MAX_DIST, m);
  endtask

  // send one box word, with an optional idle burst first; returns at acceptance
  task automatic send_box(input box_word_t w);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    entity_id = w.id;
    box_present = w.present;
    box_min_x = w.bound[0];
    box_max_x = w.bound[1];
    box_min_y = w.bound[2];
    box_max_y = w.bound[3];
    box_min_z = w.bound[4];
    box_max_z = w.bound[5];
    last_entity = w.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    track_nearest(w);
  endtask

  // wait for every expected word, then let a skipped or in-flight box finish
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic box_word_t make_box(input bit [31:0] id, input bit [31:0] b[6],
                                         input bit last);
    box_word_t w;
    w.id = id;
    w.present = 1'b1;
    w.bound = b;
    w.last = last;
    return w;
  endfunction

  function automatic box_word_t x_box(input bit [31:0] id, input bit [31:0] lo,
                                      input bit [31:0] hi, input bit last);
    bit [31:0] b[6];
    b = '{lo, hi, -fx(1), fx(1), -fx(1), fx(1)};
    return make_box(id, b, last);
  endfunction

  // random word: mostly boxes placed on the ray, some full-range noise
  function automatic box_word_t random_box();
    box_word_t w;
    longint t, p, sa, sb;
    bit [31:0] tmp;
    w.id = $urandom_range(0, 15) == 0 ? 32'd0 : $urandom;
    w.present = $urandom_range(0, 11) != 0;
    w.last = $urandom_range(0, 5) == 0;
    if ($urandom_range(0, 9) < 7) begin
      t = longint'($urandom_range(0, 32'hffff)) * (longint'(reach_limit) / 32768 + 1) / 65536
          * 2;
      for (int a = 0; a < 3; a++) begin
        p = ray_origin[a] + ((ray_dir[a] * t) >>> FB);
        sa = $urandom_range(0, 3 << FB);
        sb = $urandom_range(0, 3 << FB);
        w.bound[2*a] = sat32(p - sa);
        w.bound[2*a+1] = sat32(p + sb);
        if ($urandom_range(0, 7) == 0) begin
          tmp = w.bound[2*a];
          w.bound[2*a] = w.bound[2*a+1];
          w.bound[2*a+1] = tmp;
        end
      end
    end else begin
      foreach (w.bound[i]) w.bound[i] = $urandom;
    end
    return w;
  endfunction

  function automatic bit [31:0] random_dir();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 1) ? $urandom_range(1, 2 << FB)
                                            : -$urandom_range(1, 2 << FB);
    endcase
  endfunction

  // default ray: hits, ties, skips, inverted bounds, inside origin, misses, extremes
  task automatic test_default_ray();
    box_word_t w;
    send_box(x_box(10, fx(1), fx(2), 0));
    send_box(x_box(11, fx(1), fx(2), 0));
    send_box(x_box(0, fx(0) + 32768, fx(2), 0));
    w = x_box(14, 32768, fx(2), 0);
    w.present = 0;
    send_box(w);
    send_box(x_box(12, fx(3), 32768, 0));
    w = x_box(15, 0, fx(1), 0);
    w.bound[2] = fx(2);
    w.bound[3] = fx(3);
    send_box(w);
    send_box(x_box(13, -fx(1), fx(4), 1));
    send_box(x_box(16, -fx(3), -fx(2), 1));
    send_box(make_box(32'hffff_ffff, '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1));
    send_box(x_box(17, fx(6), fx(7), 1));
    send_box(x_box(18, fx(0), fx(1), 1));
    drain();
  endtask

  // changed reach mid-set, zero reach and full reach
  task automatic test_reach_changes();
    send_box(x_box(20, fx(4), fx(5), 0));
    drain();
    cfg_write(REG_MAX_DIST, fx(3));
    send_box(x_box(21, fx(3) + 32768, fx(5), 1));
    drain();
    cfg_write(REG_MAX_DIST, 32'd0);
    send_box(x_box(22, fx(0), fx(1), 0));
    send_box(x_box(23, fx(1), fx(2), 1));
    drain();
    cfg_write(REG_MAX_DIST, 32'hffff_ffff);
    send_box(x_box(24, fx(1000), fx(2000), 1));
    send_box(make_box(25, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1));
    drain();
  endtask

  // extreme rays: largest origins, largest and smallest direction steps
  task automatic test_extreme_rays();
    bit [31:0] o[3], d[3];
    o = '{32'h8000_0000, 32'h7fff_ffff, 32'd0};
    d = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    set_ray(o, d, 32'h7fff_ffff);
    for (int i = 0; i < 30; i++) send_box(random_box());
    send_box(x_box(30, 32'h7fff_ffff, 32'h8000_0000, 1));
    drain();
    o = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    d = '{32'h8000_0000, 32'd1, 32'd0};
    set_ray(o, d, 32'd0);
    for (int i = 0; i < 30; i++) send_box(random_box());
    send_box(x_box(31, 32'h7fff_ffff, 32'h8000_0000, 1));
    drain();
  endtask

  // random rays, each with a run of random box sets
  task automatic test_random_rays(input int phases, input int per_phase);
    bit [31:0] o[3], d[3], m;
    box_word_t w;
    for (int p = 0; p < phases; p++) begin
      if (p % 4 == 3) begin
        foreach (o[i]) o[i] = $urandom;
        foreach (d[i]) d[i] = $urandom;
        m = $urandom;
      end else begin
        foreach (o[i]) o[i] = $urandom_range(0, 1) ? $urandom_range(0, 16 << FB)
                                                   : -$urandom_range(0, 16 << FB);
        foreach (d[i]) d[i] = random_dir();
        m = $urandom_range(0, 64 << FB);
      end
      set_ray(o, d, m);
      for (int i = 0; i < per_phase; i++) begin
        w = random_box();
        if (i == per_phase - 1) w.last = 1;
        send_box(w);
      end
      drain();
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else out_ready = 1'b1;
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    hit_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) report_mismatch("result word with none expected");
      else begin
        e = expected_hits.pop_front();
        if (hit_found !== e.found)
          report_mismatch($sformatf("hit_found %b, want %b", hit_found, e.found));
        if (hit_entity_id !== e.id)
          report_mismatch($sformatf("hit_entity_id %h, want %h", hit_entity_id, e.id));
        if (hit_distance !== e.distance)
          report_mismatch($sformatf("hit_distance %h, want %h", hit_distance, e.distance));
      end
    end
  end

  initial begin
    errors = 0;
    idle_on = 1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    in_valid = 1'b0;
    entity_id = '0;
    box_present = 1'b0;
    box_min_x = '0;
    box_max_x = '0;
    box_min_y = '0;
    box_max_y = '0;
    box_min_z = '0;
    box_max_z = '0;
    last_entity = 1'b0;
    ray_origin = '{0, 0, 0};
    ray_dir = '{longint'(DIR_X_RESET), 0, 0};
    reach_limit = MAX_DIST_RESET;
    clear_nearest();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_ray();
    test_reach_changes();
    test_extreme_rays();
    test_random_rays(11, 120);
    idle_on = 0;
    test_random_rays(2, 100);

    if (expected_hits.size() != 0) report_mismatch("expected words left over");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
